### design/vcrf_pkg.sv
// Shared types and constants for the video chip register file.
package vcrf_pkg;

  // Sprite and colour register counts
  localparam int unsigned SPRITE_COUNT = 8;
  localparam int unsigned SPR_IDX_W    = $clog2(SPRITE_COUNT);
  localparam int unsigned COLOR_COUNT  = 15;

  // Bus command codes
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // Collision clear codes
  localparam logic [1:0] CLR_NONE   = 2'd0;
  localparam logic [1:0] CLR_SPR_SPR = 2'd1;
  localparam logic [1:0] CLR_SPR_GND = 2'd2;

  // Register addresses
  localparam logic [5:0] ADDR_SPR_FIRST   = 6'h00;
  localparam logic [5:0] ADDR_SPR_LAST    = 6'h0f;
  localparam logic [5:0] ADDR_SPR_XMSB    = 6'h10;
  localparam logic [5:0] ADDR_CTRL1       = 6'h11;
  localparam logic [5:0] ADDR_RASTER      = 6'h12;
  localparam logic [5:0] ADDR_PEN_X       = 6'h13;
  localparam logic [5:0] ADDR_PEN_Y       = 6'h14;
  localparam logic [5:0] ADDR_SPR_EN      = 6'h15;
  localparam logic [5:0] ADDR_CTRL2       = 6'h16;
  localparam logic [5:0] ADDR_SPR_YEXP    = 6'h17;
  localparam logic [5:0] ADDR_MEM_PTR     = 6'h18;
  localparam logic [5:0] ADDR_IRQ_LATCH   = 6'h19;
  localparam logic [5:0] ADDR_IRQ_EN      = 6'h1a;
  localparam logic [5:0] ADDR_SPR_PRIO    = 6'h1b;
  localparam logic [5:0] ADDR_SPR_MC      = 6'h1c;
  localparam logic [5:0] ADDR_SPR_XEXP    = 6'h1d;
  localparam logic [5:0] ADDR_COLL_SS     = 6'h1e;
  localparam logic [5:0] ADDR_COLL_SG     = 6'h1f;
  localparam logic [5:0] ADDR_COLOR_FIRST = 6'h20;
  localparam logic [5:0] ADDR_COLOR_LAST  = 6'h2e;

  // Readback masks for unused bits
  localparam logic [7:0] MASK_UNUSED   = 8'hff;
  localparam logic [7:0] MASK_HI_NIB   = 8'hf0;
  localparam logic [7:0] MASK_CTRL2    = 8'hc0;
  localparam logic [7:0] MASK_LATCH    = 8'h70;
  localparam logic [7:0] LATCH_IRQ_BIT = 8'h80;

  // One bus access
  typedef struct packed {
    logic       command;
    logic [5:0] address;
    logic [7:0] write_data;
    logic [8:0] raster_line;
    logic [7:0] pen_x;
    logic [7:0] pen_y;
    logic [7:0] pen_x_early;
    logic [7:0] pen_y_early;
    logic       pen_latch_late;
    logic [7:0] sprite_sprite_hits;
    logic [7:0] sprite_ground_hits;
    logic [3:0] irq_events;
  } req_t;

  // One access result
  typedef struct packed {
    logic [7:0] read_data;
    logic [1:0] collision_clear;
    logic       irq_ack;
    logic [5:0] color_written;
    logic       ecm_bmm_both_off;
    logic       prio_expand_changed;
    logic       multicolor_changed;
  } rsp_t;

endpackage

### design/vcrf_if.sv
// Valid/ready channel interfaces for bus accesses and their results.
interface vcrf_req_if;
  logic          valid;
  logic          ready;
  vcrf_pkg::req_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface vcrf_rsp_if;
  logic          valid;
  logic          ready;
  vcrf_pkg::rsp_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

### design/video_chip_register_file_unit.sv
// Register file of a video chip: one bus read or write per transfer.
//
// Usage:
//   req_i carries one bus access per transfer (command, address, write data,
//   plus the live raster line, light pen, collision and interrupt inputs).
//   rsp_o returns exactly one result per access: the readback byte (or the
//   write data echoed) and the side-effect flags of the access.
// Path: an accepted access is decoded while it sits in the input register,
//   and its result is then captured in the result register.
// Throughput: one access per cycle; the input register and the result
//   register advance together, so a new access is taken every cycle as long
//   as the result register is empty or being drained.
// Stall: when rsp_o.ready is low with a result waiting, both stages hold and
//   req_i.ready drops only once the input register is also occupied. Register
//   state changes only when an access moves into the result register.
// Reset: asynchronous, active low. Stored registers read back as zero (plus
//   the unused-bit masks; raster, pen and collision reads stay live), the
//   interrupt latch and enable are cleared and both pipeline stages are empty.
module video_chip_register_file_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  vcrf_req_if.sink             req_i,
  vcrf_rsp_if.source           rsp_o
);

  // Pipeline control
  logic           s1_valid_q;
  vcrf_pkg::req_t s1_q;
  logic           out_valid_q;
  vcrf_pkg::rsp_t out_q;
  logic           advance;
  logic           proc;

  // Register state (mode bits are kept in ctrl1_q; a write to the raster address is not stored)
  logic [7:0] spr_xlo_q [vcrf_pkg::SPRITE_COUNT];
  logic [7:0] spr_y_q   [vcrf_pkg::SPRITE_COUNT];
  logic [vcrf_pkg::SPRITE_COUNT-1:0] spr_xmsb_q;
  logic [7:0] spr_en_q, spr_yexp_q, spr_xexp_q, spr_prio_q, spr_mc_q;
  logic [7:0] ctrl1_q, ctrl2_q;
  logic [3:0] matrix_base_q;
  logic [2:0] char_base_q;
  logic [7:0] irq_latch_q, irq_latch_d;
  logic [3:0] irq_en_q;
  logic [3:0] color_q [vcrf_pkg::COLOR_COUNT];

  // Decode signals
  logic [vcrf_pkg::SPR_IDX_W-1:0] spr_idx;
  logic [3:0]     color_idx;
  logic [7:0]     cur_latch;
  logic [7:0]     rd_val;
  vcrf_pkg::rsp_t rsp_d;
  logic           is_write;

  assign advance     = !out_valid_q || rsp_o.ready;
  assign proc        = s1_valid_q && advance;
  assign req_i.ready = !s1_valid_q || advance;
  assign rsp_o.valid = out_valid_q;
  assign rsp_o.item  = out_q;

  assign spr_idx   = s1_q.address[vcrf_pkg::SPR_IDX_W:1];
  assign color_idx = s1_q.address[3:0];
  assign is_write  = (s1_q.command == vcrf_pkg::CMD_WRITE);

  // Set pending interrupt events in the latch ahead of the access
  always_comb begin
    cur_latch = irq_latch_q | {4'b0, s1_q.irq_events};
    if ((s1_q.irq_events & irq_en_q) != 4'b0) begin
      cur_latch = cur_latch | vcrf_pkg::LATCH_IRQ_BIT;
    end
  end

  // Readback mux, write side-effect flags and collision clear flag
  always_comb begin
    rd_val = vcrf_pkg::MASK_UNUSED;
    rsp_d  = '0;
    unique case (s1_q.address) inside
      [vcrf_pkg::ADDR_SPR_FIRST:vcrf_pkg::ADDR_SPR_LAST]: begin
        rd_val = s1_q.address[0] ? spr_y_q[spr_idx] : spr_xlo_q[spr_idx];
      end
      [vcrf_pkg::ADDR_COLOR_FIRST:vcrf_pkg::ADDR_COLOR_LAST]: begin
        rd_val = {4'b0, color_q[color_idx]} | vcrf_pkg::MASK_HI_NIB;
      end
      vcrf_pkg::ADDR_SPR_XMSB:  rd_val = spr_xmsb_q;
      vcrf_pkg::ADDR_CTRL1:     rd_val = {s1_q.raster_line[8], ctrl1_q[6:0]};
      vcrf_pkg::ADDR_RASTER:    rd_val = s1_q.raster_line[7:0];
      vcrf_pkg::ADDR_PEN_X:     rd_val = s1_q.pen_latch_late ? s1_q.pen_x_early : s1_q.pen_x;
      vcrf_pkg::ADDR_PEN_Y:     rd_val = s1_q.pen_latch_late ? s1_q.pen_y_early : s1_q.pen_y;
      vcrf_pkg::ADDR_SPR_EN:    rd_val = spr_en_q;
      vcrf_pkg::ADDR_CTRL2:     rd_val = ctrl2_q | vcrf_pkg::MASK_CTRL2;
      vcrf_pkg::ADDR_SPR_YEXP:  rd_val = spr_yexp_q;
      vcrf_pkg::ADDR_MEM_PTR:   rd_val = {matrix_base_q, char_base_q, 1'b1};
      vcrf_pkg::ADDR_IRQ_LATCH: rd_val = cur_latch | vcrf_pkg::MASK_LATCH;
      vcrf_pkg::ADDR_IRQ_EN:    rd_val = {4'b0, irq_en_q} | vcrf_pkg::MASK_HI_NIB;
      vcrf_pkg::ADDR_SPR_PRIO:  rd_val = spr_prio_q;
      vcrf_pkg::ADDR_SPR_MC:    rd_val = spr_mc_q;
      vcrf_pkg::ADDR_SPR_XEXP:  rd_val = spr_xexp_q;
      vcrf_pkg::ADDR_COLL_SS:   rd_val = s1_q.sprite_sprite_hits;
      vcrf_pkg::ADDR_COLL_SG:   rd_val = s1_q.sprite_ground_hits;
      default:                  rd_val = vcrf_pkg::MASK_UNUSED;
    endcase

    if (is_write) begin
      rsp_d.read_data = s1_q.write_data;
      case (s1_q.address) inside
        [vcrf_pkg::ADDR_COLOR_FIRST:vcrf_pkg::ADDR_COLOR_LAST]:
          rsp_d.color_written = s1_q.address;
        vcrf_pkg::ADDR_CTRL1:
          rsp_d.ecm_bmm_both_off = (s1_q.write_data[6:5] == 2'b00) &&
                                   (ctrl1_q[6:5] == 2'b11);
        vcrf_pkg::ADDR_IRQ_LATCH, vcrf_pkg::ADDR_IRQ_EN:
          rsp_d.irq_ack = 1'b1;
        vcrf_pkg::ADDR_SPR_PRIO, vcrf_pkg::ADDR_SPR_XEXP:
          rsp_d.prio_expand_changed = 1'b1;
        vcrf_pkg::ADDR_SPR_MC:
          rsp_d.multicolor_changed = 1'b1;
        default: ;
      endcase
    end else begin
      rsp_d.read_data = rd_val;
      if (s1_q.address == vcrf_pkg::ADDR_COLL_SS) begin
        rsp_d.collision_clear = vcrf_pkg::CLR_SPR_SPR;
      end else if (s1_q.address == vcrf_pkg::ADDR_COLL_SG) begin
        rsp_d.collision_clear = vcrf_pkg::CLR_SPR_GND;
      end
    end
  end

  // Latch next value: events set, a latch write clears bits
  always_comb begin
    irq_latch_d = cur_latch;
    if (is_write && s1_q.address == vcrf_pkg::ADDR_IRQ_LATCH) begin
      irq_latch_d = cur_latch & ~({4'b0, s1_q.write_data[3:0]} | vcrf_pkg::LATCH_IRQ_BIT);
    end
  end

  // Advance the pipeline valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (req_i.ready) begin
        s1_valid_q <= req_i.valid;
      end
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // Hold payloads while stalled
  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      s1_q <= req_i.item;
    end
    if (proc) begin
      out_q <= rsp_d;
    end
  end

  // Update register state as each access retires
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < vcrf_pkg::SPRITE_COUNT; i++) begin
        spr_xlo_q[i] <= '0;
        spr_y_q[i]   <= '0;
      end
      for (int i = 0; i < vcrf_pkg::COLOR_COUNT; i++) begin
        color_q[i] <= '0;
      end
      spr_xmsb_q    <= '0;
      spr_en_q      <= '0;
      spr_yexp_q    <= '0;
      spr_xexp_q    <= '0;
      spr_prio_q    <= '0;
      spr_mc_q      <= '0;
      ctrl1_q       <= '0;
      ctrl2_q       <= '0;
      matrix_base_q <= '0;
      char_base_q   <= '0;
      irq_latch_q   <= '0;
      irq_en_q      <= '0;
    end else if (proc) begin
      irq_latch_q <= irq_latch_d;
      if (is_write) begin
        case (s1_q.address) inside
          [vcrf_pkg::ADDR_SPR_FIRST:vcrf_pkg::ADDR_SPR_LAST]: begin
            if (s1_q.address[0]) begin
              spr_y_q[spr_idx] <= s1_q.write_data;
            end else begin
              spr_xlo_q[spr_idx] <= s1_q.write_data;
            end
          end
          [vcrf_pkg::ADDR_COLOR_FIRST:vcrf_pkg::ADDR_COLOR_LAST]:
            color_q[color_idx] <= s1_q.write_data[3:0];
          vcrf_pkg::ADDR_SPR_XMSB:  spr_xmsb_q <= s1_q.write_data;
          vcrf_pkg::ADDR_CTRL1:     ctrl1_q    <= s1_q.write_data;
          vcrf_pkg::ADDR_SPR_EN:    spr_en_q   <= s1_q.write_data;
          vcrf_pkg::ADDR_CTRL2:     ctrl2_q    <= s1_q.write_data;
          vcrf_pkg::ADDR_SPR_YEXP:  spr_yexp_q <= s1_q.write_data;
          vcrf_pkg::ADDR_MEM_PTR: begin
            matrix_base_q <= s1_q.write_data[7:4];
            char_base_q   <= s1_q.write_data[3:1];
          end
          vcrf_pkg::ADDR_IRQ_EN:    irq_en_q   <= s1_q.write_data[3:0];
          vcrf_pkg::ADDR_SPR_PRIO:  spr_prio_q <= s1_q.write_data;
          vcrf_pkg::ADDR_SPR_MC:    spr_mc_q   <= s1_q.write_data;
          vcrf_pkg::ADDR_SPR_XEXP:  spr_xexp_q <= s1_q.write_data;
          default: ;
        endcase
      end
    end
  end

  // Latch bits 6..4 have no source and must stay clear
  a_latch_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    irq_latch_q[6:4] == 3'b000)
    else $error("interrupt latch unused bits set");

  // A collision clear comes only from a read, so no write flag goes with it
  a_clear_is_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.item.collision_clear != vcrf_pkg::CLR_NONE) |->
    (!rsp_o.item.irq_ack && rsp_o.item.color_written == 6'd0 &&
     !rsp_o.item.ecm_bmm_both_off && !rsp_o.item.prio_expand_changed &&
     !rsp_o.item.multicolor_changed))
    else $error("collision clear reported together with write flags");

  // A reported colour address lies in the colour window
  a_color_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.item.color_written != 6'd0) |->
    (rsp_o.item.color_written >= vcrf_pkg::ADDR_COLOR_FIRST &&
     rsp_o.item.color_written <= vcrf_pkg::ADDR_COLOR_LAST))
    else $error("colour write address out of range");

  // A stalled access stays in the input register
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !advance) |=> (s1_valid_q && $stable(s1_q)))
    else $error("stalled access lost from input register");

  // At most one register-change flag per write
  a_one_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> $onehot0({rsp_o.item.irq_ack, rsp_o.item.ecm_bmm_both_off,
                              rsp_o.item.prio_expand_changed,
                              rsp_o.item.multicolor_changed}))
    else $error("more than one write flag in a result");

endmodule
